[rtl/core/pre_pkg.sv]
`default_nettype none
package pre_pkg;
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * VALUE_BITS;
  localparam int ACC_BITS = PROD_BITS + 4;
  localparam int NUM_BITS = VALUE_BITS + FRAC_BITS;
  localparam int RAD_BITS = 2 * VALUE_BITS + 4;
  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int ERR_BITS = 32;
  localparam int SUM_BITS = 48;
  localparam int STORE_DEPTH = 21;
  localparam int E_BASE = 9;
  localparam int K_COUNT = 9;
  localparam int E_COUNT = 12;

  typedef enum logic [1:0] {
    CMD_K_WRITE = 2'd0,
    CMD_E_WRITE = 2'd1,
    CMD_POINT   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // one point request handed from front to back
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] px;
    logic signed [VALUE_BITS-1:0] py;
    logic signed [VALUE_BITS-1:0] pz;
    logic signed [VALUE_BITS-1:0] pu;
    logic signed [VALUE_BITS-1:0] pv;
    logic                         restart;
  } point_req_t;

  // round half up dropping FRAC_BITS and saturate to signed VALUE_BITS
  function automatic logic signed [VALUE_BITS-1:0] round_sat(
    input logic signed [ACC_BITS-1:0] a
  );
    logic signed [ACC_BITS-1:0] s;
    logic signed [ACC_BITS-1:0] mx;
    logic signed [ACC_BITS-1:0] mn;
    s = (a + (ACC_BITS'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    mx = (ACC_BITS'(1) <<< (VALUE_BITS - 1)) - ACC_BITS'(1);
    mn = -(ACC_BITS'(1) <<< (VALUE_BITS - 1));
    if (s > mx) return mx[VALUE_BITS-1:0];
    else if (s < mn) return mn[VALUE_BITS-1:0];
    else return s[VALUE_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

[rtl/core/pre_front.sv]
`default_nettype none
module pre_front import pre_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_cmd,
  input  wire logic [3:0]             in_entry_index,
  input  wire logic [VALUE_BITS-1:0]  in_entry_value,
  input  wire logic [VALUE_BITS-1:0]  in_point_x,
  input  wire logic [VALUE_BITS-1:0]  in_point_y,
  input  wire logic [VALUE_BITS-1:0]  in_point_z,
  input  wire logic [VALUE_BITS-1:0]  in_pixel_u,
  input  wire logic [VALUE_BITS-1:0]  in_pixel_v,
  input  wire logic                   in_restart_sum,
  input  wire logic                   back_busy,
  output logic                        wr_en,
  output logic [4:0]                  wr_addr,
  output logic [VALUE_BITS-1:0]       wr_data,
  output logic                        q_valid,
  input  wire logic                   q_ready,
  output point_req_t                  q_data
);
  // two-entry request queue
  point_req_t q_mem_r [2];
  logic       q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  cmd_t       cmd;
  logic       acc, push, pop, ld_ok;

  assign cmd = cmd_t'(in_cmd);
  // loads wait until queued and running points are done
  assign ld_ok = (q_cnt_r == 2'd0) && !back_busy;
  always_comb begin
    unique case (cmd)
      CMD_K_WRITE, CMD_E_WRITE: in_ready = ld_ok;
      CMD_POINT:                in_ready = (q_cnt_r != 2'd2);
      default:                  in_ready = 1'b1;
    endcase
  end
  assign acc = in_valid && in_ready;
  assign push = acc && (cmd == CMD_POINT);
  assign pop = q_valid && q_ready;
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_data = q_mem_r[q_rp_r];

  // store write decode
  always_comb begin
    wr_en = 1'b0;
    wr_addr = 5'(in_entry_index);
    wr_data = in_entry_value;
    if (acc && cmd == CMD_K_WRITE && in_entry_index < 4'(K_COUNT)) begin
      wr_en = 1'b1;
    end else if (acc && cmd == CMD_E_WRITE && in_entry_index < 4'(E_COUNT)) begin
      wr_en = 1'b1;
      wr_addr = 5'(in_entry_index) + 5'(E_BASE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= !q_wp_r;
      if (pop) q_rp_r <= !q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wp_r] <= '{px: in_point_x, py: in_point_y, pz: in_point_z,
                          pu: in_pixel_u, pv: in_pixel_v, restart: in_restart_sum};
    end
  end
endmodule
`default_nettype wire

[rtl/core/pre_back.sv]
`default_nettype none
module pre_back import pre_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [4:0]            wr_addr,
  input  wire logic [VALUE_BITS-1:0] wr_data,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire point_req_t            q_data,
  output logic                       busy,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ERR_BITS-1:0]        out_point_error,
  output logic [SUM_BITS-1:0]        out_running_total,
  output logic                       out_degenerate_depth
);
  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_ROUND, S_DIVSET, S_DIV, S_DIVFIX, S_DIFF, S_SQ, S_SQRT, S_DONE
  } state_t;

  localparam int QB = NUM_BITS;
  localparam int CW = $clog2(QB + 1) + 1;

  // matrix store, flip-flops read combinationally by the operand select
  logic [VALUE_BITS-1:0] mat_r [STORE_DEPTH];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) mat_r[i] <= '0;
    end else if (wr_en) begin
      mat_r[wr_addr] <= wr_data;
    end
  end

  state_t                       st_r;
  point_req_t                   pt_r;
  logic                         phase_r;   // 0 camera, 1 image
  logic [1:0]                   row_r;
  logic [1:0]                   col_r;
  logic signed [ACC_BITS-1:0]   acc_r;
  logic signed [VALUE_BITS-1:0] cam_r [3];
  logic signed [VALUE_BITS-1:0] img_r [3];
  logic signed [PROD_BITS-1:0]  prod_r;
  logic                         prod_v_r;
  logic                         div_sel_r;  // 0 u, 1 v
  logic [QB-1:0]                dq_r;
  logic [VALUE_BITS:0]          drem_r;
  logic [VALUE_BITS:0]          dden_r;
  logic                         dneg_r;
  logic [CW-1:0]                cnt_r;
  logic signed [VALUE_BITS-1:0] uq_r, vq_r;
  logic [VALUE_BITS:0]          du_r, dv_r;
  logic [RAD_BITS-1:0]          rad_r;
  logic [ROOT_BITS-1:0]         root_r;
  logic [RAD_BITS-1:0]          srem_r;
  logic                         sq_ph_r;
  logic [ERR_BITS-1:0]          err_r;
  logic [SUM_BITS-1:0]          sum_r;
  logic                         deg_r;

  // operand select for the shared multiplier
  logic signed [VALUE_BITS-1:0] ma, mb;
  logic [4:0] ia;
  always_comb begin
    if (!phase_r) begin
      ia = 5'(E_BASE) + 5'({row_r, 2'b00}) + 5'(col_r);
      unique case (col_r)
        2'd0: mb = pt_r.px;
        2'd1: mb = pt_r.py;
        2'd2: mb = pt_r.pz;
        default: mb = VALUE_BITS'(1) <<< FRAC_BITS;
      endcase
    end else begin
      ia = 5'(row_r) * 5'd3 + 5'(col_r);
      mb = cam_r[col_r[1:0] == 2'd3 ? 2'd0 : col_r];
    end
    ma = mat_r[ia];
  end
  logic last_col;
  assign last_col = phase_r ? (col_r == 2'd2) : (col_r == 2'd3);

  // division step
  logic [VALUE_BITS+1:0] dsh;
  assign dsh = {drem_r, 1'b0};
  logic [QB-1:0] qmag;
  logic signed [NUM_BITS+1:0] qs;
  logic signed [VALUE_BITS-1:0] qsat;
  always_comb begin
    qmag = dq_r;
    qs = dneg_r ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    if (qs > $signed((NUM_BITS+2)'((64'd1 << (VALUE_BITS-1)) - 1)))
      qsat = {1'b0, {(VALUE_BITS-1){1'b1}}};
    else if (qs < -$signed((NUM_BITS+2)'(64'd1 << (VALUE_BITS-1))))
      qsat = {1'b1, {(VALUE_BITS-1){1'b0}}};
    else qsat = qs[VALUE_BITS-1:0];
  end
  logic [VALUE_BITS-1:0] num_mag;
  logic signed [VALUE_BITS-1:0] num_s;
  assign num_s = div_sel_r ? img_r[1] : img_r[0];
  assign num_mag = num_s[VALUE_BITS-1] ? VALUE_BITS'(-num_s) : num_s;
  logic [NUM_BITS-1:0] numer_r;

  // square root step (bit pair restoring)
  logic [RAD_BITS-1:0] strial;
  assign strial = RAD_BITS'({root_r, 2'b01});
  logic [RAD_BITS-1:0] scur;
  assign scur = {srem_r[RAD_BITS-3:0], rad_r[RAD_BITS-1:RAD_BITS-2]};

  // shared squarer
  logic [VALUE_BITS:0] sq_m;
  logic [2*VALUE_BITS+1:0] sq_p;
  assign sq_m = sq_ph_r ? dv_r : du_r;
  assign sq_p = sq_m * sq_m;

  // saturated root and running sum update
  logic [ERR_BITS-1:0] root_sat;
  assign root_sat = (root_r >> ERR_BITS) != '0 ? '1 : root_r[ERR_BITS-1:0];
  logic [SUM_BITS:0] sum_add;
  assign sum_add = (pt_r.restart ? '0 : {1'b0, sum_r}) +
                   (SUM_BITS+1)'(deg_r ? {ERR_BITS{1'b1}} : root_sat);

  logic signed [VALUE_BITS+1:0] du_s, dv_s;
  assign du_s = $signed({uq_r[VALUE_BITS-1], uq_r}) - $signed({pt_r.pu[VALUE_BITS-1], pt_r.pu});
  assign dv_s = $signed({vq_r[VALUE_BITS-1], vq_r}) - $signed({pt_r.pv[VALUE_BITS-1], pt_r.pv});

  assign q_ready = (st_r == S_IDLE);
  assign busy = (st_r != S_IDLE);
  assign out_valid = (st_r == S_DONE);
  assign out_point_error = err_r;
  assign out_running_total = sum_r;
  assign out_degenerate_depth = deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      sum_r <= '0;
      prod_v_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          pt_r <= q_data;
          phase_r <= 1'b0;
          row_r <= 2'd0;
          col_r <= 2'd0;
          acc_r <= '0;
          prod_v_r <= 1'b0;
          st_r <= S_MAC;
        end
        // one product per cycle, registered and accumulated in the next cycle
        S_MAC: begin
          prod_r <= ma * mb;
          prod_v_r <= 1'b1;
          if (prod_v_r) acc_r <= acc_r + ACC_BITS'(prod_r);
          if (last_col) st_r <= S_ROUND;
          else col_r <= col_r + 2'd1;
        end
        S_ROUND: begin
          prod_v_r <= 1'b0;
          acc_r <= '0;
          col_r <= 2'd0;
          if (!phase_r) cam_r[row_r] <= round_sat(acc_r + ACC_BITS'(prod_r));
          else img_r[row_r] <= round_sat(acc_r + ACC_BITS'(prod_r));
          if (row_r == 2'd2) begin
            row_r <= 2'd0;
            if (!phase_r) begin
              phase_r <= 1'b1;
              st_r <= S_MAC;
            end else begin
              div_sel_r <= 1'b0;
              st_r <= S_DIVSET;
            end
          end else begin
            row_r <= row_r + 2'd1;
            st_r <= S_MAC;
          end
        end
        S_DIVSET: begin
          if (img_r[2] == '0) begin
            deg_r <= 1'b1;
            err_r <= '1;
            st_r <= S_SQRT;
            cnt_r <= '0;
          end else begin
            deg_r <= 1'b0;
            numer_r <= {num_mag, {FRAC_BITS{1'b0}}};
            dden_r <= {1'b0, img_r[2][VALUE_BITS-1] ? VALUE_BITS'(-img_r[2]) : img_r[2]};
            dneg_r <= num_s[VALUE_BITS-1] ^ img_r[2][VALUE_BITS-1];
            drem_r <= '0;
            dq_r <= '0;
            cnt_r <= CW'(QB);
            st_r <= S_DIV;
          end
        end
        // restoring division, one quotient bit per cycle
        S_DIV: begin
          if (cnt_r == '0) st_r <= S_DIVFIX;
          else begin
            cnt_r <= cnt_r - CW'(1);
            numer_r <= numer_r << 1;
            if ({dsh[VALUE_BITS:1], numer_r[NUM_BITS-1]} >= {1'b0, dden_r}) begin
              drem_r <= (VALUE_BITS+1)'({dsh[VALUE_BITS:1], numer_r[NUM_BITS-1]} -
                                        {1'b0, dden_r});
              dq_r <= {dq_r[QB-2:0], 1'b1};
            end else begin
              drem_r <= {drem_r[VALUE_BITS-1:0], numer_r[NUM_BITS-1]};
              dq_r <= {dq_r[QB-2:0], 1'b0};
            end
          end
        end
        S_DIVFIX: begin
          if (!div_sel_r) begin
            uq_r <= qsat;
            div_sel_r <= 1'b1;
            st_r <= S_DIVSET;
          end else begin
            vq_r <= qsat;
            st_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          du_r <= du_s[VALUE_BITS+1] ? (VALUE_BITS+1)'(-du_s) : du_s[VALUE_BITS:0];
          dv_r <= dv_s[VALUE_BITS+1] ? (VALUE_BITS+1)'(-dv_s) : dv_s[VALUE_BITS:0];
          sq_ph_r <= 1'b0;
          rad_r <= '0;
          st_r <= S_SQ;
        end
        // two squares in turn through the shared squarer, summed into the radicand
        S_SQ: begin
          if (!sq_ph_r) begin
            rad_r <= RAD_BITS'(sq_p);
            sq_ph_r <= 1'b1;
          end else begin
            rad_r <= rad_r + RAD_BITS'(sq_p);
            root_r <= '0;
            srem_r <= '0;
            cnt_r <= CW'(ROOT_BITS);
            st_r <= S_SQRT;
          end
        end
        // digit-by-digit root, one bit per cycle
        S_SQRT: begin
          if (deg_r || cnt_r == '0) begin
            if (!deg_r) err_r <= root_sat;
            sum_r <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
            st_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r - CW'(1);
            rad_r <= rad_r << 2;
            if (scur >= strial) begin
              srem_r <= scur - strial;
              root_r <= {root_r[ROOT_BITS-2:0], 1'b1};
            end else begin
              srem_r <= scur;
              root_r <= {root_r[ROOT_BITS-2:0], 1'b0};
            end
          end
        end
        S_DONE: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/point_reprojection_error_unit.sv]
// a point passes through pickup, the camera and image projections, two 48-bit
// quotients, difference and square, and the root
// zero depth skips divide and root; loads wait until queue and back end are idle
// the back end handles one point at a time and holds its result until out_ready
// the two-entry request queue lets new points be taken while one is processed
// reset (rst_n low, synchronous) clears the matrices, running sum and queue
`default_nettype none
module point_reprojection_error_unit import pre_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [3:0]            in_entry_index,
  input  wire logic [VALUE_BITS-1:0] in_entry_value,
  input  wire logic [VALUE_BITS-1:0] in_point_x,
  input  wire logic [VALUE_BITS-1:0] in_point_y,
  input  wire logic [VALUE_BITS-1:0] in_point_z,
  input  wire logic [VALUE_BITS-1:0] in_pixel_u,
  input  wire logic [VALUE_BITS-1:0] in_pixel_v,
  input  wire logic                  in_restart_sum,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ERR_BITS-1:0]        out_point_error,
  output logic [SUM_BITS-1:0]        out_running_total,
  output logic                       out_degenerate_depth
);
  logic wr_en, q_valid, q_ready, busy;
  logic [4:0] wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  point_req_t q_data;

  // front: accept and classify requests
  pre_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_entry_index, .in_entry_value,
    .in_point_x, .in_point_y, .in_point_z, .in_pixel_u, .in_pixel_v, .in_restart_sum,
    .back_busy(busy), .wr_en, .wr_addr, .wr_data, .q_valid, .q_ready, .q_data
  );

  // back: projection, divide, root, sum
  pre_back u_back (
    .clk, .rst_n, .wr_en, .wr_addr, .wr_data, .q_valid, .q_ready, .q_data, .busy,
    .out_valid, .out_ready, .out_point_error, .out_running_total, .out_degenerate_depth
  );
endmodule
`default_nettype wire

[sim/tb_top.sv]
`default_nettype none
module tb_top;
  import pre_pkg::*;

  typedef struct {
    logic [ERR_BITS-1:0] err;
    logic [SUM_BITS-1:0] total;
    logic                deg;
  } reproj_result_t;

  // tracks matrices and running sum, predicts one result per point request
  class reproj_scoreboard;
    logic [VALUE_BITS-1:0] mats [STORE_DEPTH];
    logic [SUM_BITS-1:0]   err_sum;
    reproj_result_t        pending [$];
    int                    fails;
    int                    points_seen;
    int                    degenerate_seen;
    int                    loads_seen;

    function new();
      foreach (mats[i]) mats[i] = '0;
      err_sum = '0;
      fails = 0;
      points_seen = 0;
      degenerate_seen = 0;
      loads_seen = 0;
    endfunction

    // round half up dropping fraction bits, clamp to signed value width
    function logic signed [127:0] round_clamp(logic signed [127:0] a);
      logic signed [127:0] s;
      s = (a + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (s > 128'sd2147483647) return 128'sd2147483647;
      if (s < -128'sd2147483648) return -128'sd2147483648;
      return s;
    endfunction

    function logic signed [127:0] entry_of(int i);
      logic signed [127:0] e;
      e = $signed(mats[i]);
      return e;
    endfunction

    // (num << F) / den truncated toward zero, clamped
    function logic signed [127:0] quotient(logic signed [127:0] num,
                                           logic signed [127:0] den);
      logic [127:0] n;
      logic [127:0] d;
      logic signed [127:0] q;
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = $signed((n << FRAC_BITS) / d);
      if ((num < 0) != (den < 0)) q = -q;
      if (q > 128'sd2147483647) return 128'sd2147483647;
      if (q < -128'sd2147483648) return -128'sd2147483648;
      return q;
    endfunction

    function void note_request(logic [1:0] cmd, logic [3:0] idx, logic [31:0] val,
                               logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [31:0] pu, logic [31:0] pv, logic rs);
      logic signed [127:0] pt [3];
      logic signed [127:0] cam [3];
      logic signed [127:0] img [3];
      logic signed [127:0] acc;
      logic signed [127:0] du;
      logic signed [127:0] dv;
      logic [127:0] rad;
      logic [127:0] root;
      logic [127:0] cand;
      logic [63:0] nxt;
      reproj_result_t r;
      if (cmd == CMD_K_WRITE) begin
        if (idx < K_COUNT) mats[idx] = val;
        loads_seen++;
        return;
      end
      if (cmd == CMD_E_WRITE) begin
        if (idx < E_COUNT) mats[E_BASE + idx] = val;
        loads_seen++;
        return;
      end
      if (cmd != CMD_POINT) return;
      pt[0] = $signed(px);
      pt[1] = $signed(py);
      pt[2] = $signed(pz);
      // camera coordinates from the extrinsic matrix
      for (int row = 0; row < 3; row++) begin
        acc = entry_of(E_BASE + row * 4 + 3) <<< FRAC_BITS;
        for (int c = 0; c < 3; c++) acc += entry_of(E_BASE + row * 4 + c) * pt[c];
        cam[row] = round_clamp(acc);
      end
      // homogeneous image coordinates from the intrinsic matrix
      for (int row = 0; row < 3; row++) begin
        acc = '0;
        for (int c = 0; c < 3; c++) acc += entry_of(row * 3 + c) * cam[c];
        img[row] = round_clamp(acc);
      end
      r.err = '1;
      r.deg = 1'b1;
      if (img[2] != 0) begin
        du = quotient(img[0], img[2]) - $signed(pu);
        dv = quotient(img[1], img[2]) - $signed(pv);
        rad = du * du + dv * dv;
        root = '0;
        for (int b = 40; b >= 0; b--) begin
          cand = root | (128'd1 << b);
          if (cand * cand <= rad) root = cand;
        end
        r.err = (root > 128'hFFFF_FFFF) ? '1 : root[31:0];
        r.deg = 1'b0;
      end
      nxt = (rs ? 64'd0 : {16'd0, err_sum}) + {32'd0, r.err};
      err_sum = (nxt > 64'hFFFF_FFFF_FFFF) ? '1 : nxt[47:0];
      r.total = err_sum;
      points_seen++;
      if (r.deg) degenerate_seen++;
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] err, logic [47:0] total, logic deg);
      reproj_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result err=%h total=%h deg=%b", $time, err, total, deg);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (err !== e.err) begin
        $display("%0t: point_error expected %h actual %h", $time, e.err, err);
        fails++;
      end
      if (total !== e.total) begin
        $display("%0t: running_total expected %h actual %h", $time, e.total, total);
        fails++;
      end
      if (deg !== e.deg) begin
        $display("%0t: degenerate_depth expected %b actual %b", $time, e.deg, deg);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_cmd = '0;
  logic [3:0] in_entry_index = '0;
  logic [31:0] in_entry_value = '0;
  logic [31:0] in_point_x = '0;
  logic [31:0] in_point_y = '0;
  logic [31:0] in_point_z = '0;
  logic [31:0] in_pixel_u = '0;
  logic [31:0] in_pixel_v = '0;
  logic in_restart_sum = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ERR_BITS-1:0] out_point_error;
  logic [SUM_BITS-1:0] out_running_total;
  logic out_degenerate_depth;
  logic no_gaps = 1'b0;

  reproj_scoreboard sb = new();

  point_reprojection_error_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_entry_index(in_entry_index), .in_entry_value(in_entry_value),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_pixel_u(in_pixel_u), .in_pixel_v(in_pixel_v), .in_restart_sum(in_restart_sum),
    .out_valid(out_valid), .out_ready(out_ready), .out_point_error(out_point_error),
    .out_running_total(out_running_total), .out_degenerate_depth(out_degenerate_depth)
  );

  always #5 clk = ~clk;

  // hard stop
  initial begin
    #30000000;
    $display("TEST FAILED");
    $finish;
  end

  // result side with random stalls
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_point_error, out_running_total, out_degenerate_depth);
  end

  // one request, with a random gap ahead of it
  task automatic send(logic [1:0] cmd, logic [3:0] idx, logic [31:0] val,
                      logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                      logic [31:0] pu, logic [31:0] pv, logic rs);
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 8);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    in_pixel_u <= pu;
    in_pixel_v <= pv;
    in_restart_sum <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(cmd, idx, val, px, py, pz, pu, pv, rs);
  endtask

  task automatic load(logic [1:0] cmd, logic [3:0] idx, logic [31:0] val);
    send(cmd, idx, val, $urandom, $urandom, $urandom, $urandom, $urandom,
         1'($urandom_range(0, 1)));
  endtask

  task automatic point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                       logic [31:0] pu, logic [31:0] pv, logic rs);
    send(CMD_POINT, 4'($urandom), $urandom, px, py, pz, pu, pv, rs);
  endtask

  function automatic logic [31:0] near(int whole);
    return $signed(whole) * 65536 + $signed($urandom_range(0, 65535)) - 32768;
  endfunction

  // plausible camera: rotation-like extrinsics and focal/center intrinsics
  task automatic load_camera();
    for (int i = 0; i < E_COUNT; i++)
      load(CMD_E_WRITE, 4'(i), (i % 4 == 3) ? near($urandom_range(0, 20) - 10) :
           ((i / 4 == i % 4) ? near(1) : $signed($urandom_range(0, 40000)) - 20000));
    for (int i = 0; i < K_COUNT; i++) begin
      case (i)
        0, 4: load(CMD_K_WRITE, 4'(i), near($urandom_range(100, 1500)));
        2, 5: load(CMD_K_WRITE, 4'(i), near($urandom_range(0, 800)));
        8: load(CMD_K_WRITE, 4'(i), ($urandom_range(0, 15) == 0) ? 32'd0 : 32'h0001_0000);
        default: load(CMD_K_WRITE, 4'(i),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 2000) : 0);
      endcase
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int kind;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero matrices give zero depth
    point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 1'b1);
    // identity camera, unit intrinsics
    for (int i = 0; i < E_COUNT; i++)
      load(CMD_E_WRITE, 4'(i), (i % 4 == i / 4) ? 32'h0001_0000 : 32'd0);
    for (int i = 0; i < K_COUNT; i++)
      load(CMD_K_WRITE, 4'(i), (i % 3 == i / 3) ? 32'h0001_0000 : 32'd0);
    point(32'h0002_0000, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 1'b1);
    point(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 0, 0, 1'b0);
    // extremes of the point and pixel fields
    point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    point(0, 0, 0, 0, 0, 1'b0);
    // bad load indices and unused command are ignored
    load(CMD_K_WRITE, 4'd9, 32'h7FFF_FFFF);
    load(CMD_K_WRITE, 4'd15, 32'h8000_0000);
    load(CMD_E_WRITE, 4'd12, 32'h8000_0000);
    load(CMD_E_WRITE, 4'd15, 32'hFFFF_FFFF);
    send(CMD_NONE, 4'd0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 1'b1);
    // extreme matrix entries saturate the coordinates
    load(CMD_E_WRITE, 4'd3, 32'h7FFF_FFFF);
    load(CMD_K_WRITE, 4'd0, 32'h8000_0000);
    point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1'b1);

    // random: mostly sane cameras and points, some noise
    for (int n = 0; n < 1000; n++) begin
      if (n % 150 == 0) no_gaps <= ($urandom_range(0, 2) == 0);
      if (n == 600) wait_drained();
      kind = $urandom_range(0, 99);
      if (n % 100 == 0) load_camera();
      else if (kind < 75)
        point(near($urandom_range(0, 20) - 10), near($urandom_range(0, 20) - 10),
              near($urandom_range(0, 40)), near($urandom_range(0, 1600)),
              near($urandom_range(0, 1200)), $urandom_range(0, 15) == 0);
      else if (kind < 85)
        point($urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      else if (kind < 95)
        load(2'($urandom_range(0, 1)), 4'($urandom), $urandom_range(0, 1) ? $urandom :
             near($urandom_range(0, 4) - 2));
      else
        send(CMD_NONE, 4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, 1'($urandom_range(0, 1)));
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d points (%0d with zero depth) and %0d matrix loads",
             sb.points_seen, sb.degenerate_seen, sb.loads_seen);
    $display("random gaps and stalls on both sides, with stretches of full rate");
    if (sb.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
